// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// Depends on clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SADQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SADQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sadq_pkg.sv =====
// Types and constants for the shared-array dual queue.
// Used by sadq_ptr and shared_array_dual_queue_top.
package sadq_pkg;

  localparam int unsigned DefDepth     = 8;
  localparam int unsigned DefDataWidth = 32;
  localparam int unsigned FieldW       = 32;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_L = 2'd0,
    MODE_PUSH_R = 2'd1,
    MODE_POP    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    logic    pop_ok;
  } sadq_res_t;

  typedef struct packed {
    logic full;
    logic l_empty;
    logic r_empty;
  } sadq_flags_t;

endpackage

// ===== design/sadq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sadq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sadq_ptr.sv =====
// Head and tail pointers of both queues, full/empty decode and RAM addressing.
// Depends on sadq_pkg.
module sadq_ptr #(
  parameter int unsigned DEPTH = sadq_pkg::DefDepth,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned PW   = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  sadq_pkg::mode_e      mode_i,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o,
  output sadq_pkg::sadq_res_t  res_o,
  output sadq_pkg::sadq_flags_t flags_o
);
  import sadq_pkg::*;

  localparam logic [PW-1:0] PtrTop  = PW'(DEPTH);
  localparam logic [AW-1:0] HeadTop = AW'(DEPTH - 1);

  logic [PW-1:0] lend_q, lend_d, rtail_q, rtail_d;
  logic [AW-1:0] lhead_q, lhead_d, rhead_q, rhead_d;
  logic          full, l_empty, r_empty;
  logic [PW-1:0] rtail_m1;

  assign full     = (lend_q == rtail_q);
  assign l_empty  = (lend_q == '0);
  assign r_empty  = (rtail_q == PtrTop);
  assign rtail_m1 = rtail_q - PW'(1);

  always_comb begin
    lend_d        = lend_q;
    lhead_d       = lhead_q;
    rtail_d       = rtail_q;
    rhead_d       = rhead_q;
    we_o          = 1'b0;
    waddr_o       = lend_q[AW-1:0];
    re_o          = 1'b0;
    raddr_o       = lhead_q;
    res_o.status  = ST_OK;
    res_o.pop_ok  = 1'b0;
    unique case (mode_i)
      MODE_PUSH_L: begin
        if (full) begin
          res_o.status = ST_OVERFLOW;
        end else begin
          we_o    = acc_i;
          waddr_o = lend_q[AW-1:0];
          lend_d  = lend_q + PW'(1);
        end
      end
      MODE_PUSH_R: begin
        if (full) begin
          res_o.status = ST_OVERFLOW;
        end else begin
          we_o    = acc_i;
          waddr_o = rtail_m1[AW-1:0];
          rtail_d = rtail_m1;
        end
      end
      MODE_POP: begin
        if (!l_empty) begin
          re_o         = acc_i;
          raddr_o      = lhead_q;
          res_o.pop_ok = 1'b1;
          if (PW'(lhead_q) + PW'(1) == lend_q) begin
            lend_d  = '0;
            lhead_d = '0;
          end else begin
            lhead_d = lhead_q + AW'(1);
          end
        end else if (!r_empty) begin
          re_o         = acc_i;
          raddr_o      = rhead_q;
          res_o.pop_ok = 1'b1;
          if (PW'(rhead_q) == rtail_q) begin
            rtail_d = PtrTop;
            rhead_d = HeadTop;
          end else begin
            rhead_d = rhead_q - AW'(1);
          end
        end else begin
          res_o.status = ST_UNDERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lend_q  <= '0;
      lhead_q <= '0;
      rtail_q <= PtrTop;
      rhead_q <= HeadTop;
    end else if (acc_i) begin
      lend_q  <= lend_d;
      lhead_q <= lhead_d;
      rtail_q <= rtail_d;
      rhead_q <= rhead_d;
    end
  end

  assign flags_o.full    = full;
  assign flags_o.l_empty = l_empty;
  assign flags_o.r_empty = r_empty;

endmodule

// ===== design/shared_array_dual_queue_top.sv =====
// Top level of the shared-array dual queue: pointer unit, slot RAM, result stages.
// Depends on sadq_pkg, sadq_ptr, sadq_ram and assert_macros.svh.
//
//   channel | handshake                   | payload
//   in      | in_valid_i / in_stall_o     | mode_i, push_data_i
//   out     | out_valid_o / out_stall_i   | pop_data_o, status_o
//
// One transfer in per cycle while in_stall_o is low; its result is registered in the
// read port of the slot RAM and then in the output register before it leaves.
// Reset empties both queues at once; slot contents are not cleared.
// A stalled output holds, and one more transfer is taken into the middle stage
// before in_stall_o rises.
module shared_array_dual_queue_top #(
  parameter int unsigned DEPTH      = sadq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = sadq_pkg::DefDataWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sadq_pkg::ModeW-1:0]  mode_i,
  input  logic signed [sadq_pkg::FieldW-1:0] push_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [sadq_pkg::FieldW-1:0] pop_data_o,
  output logic [sadq_pkg::StatusW-1:0] status_o
);
  import sadq_pkg::*;
`include "assert_macros.svh"

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WideW = (DATA_WIDTH > FieldW) ? DATA_WIDTH : FieldW;

  logic                  in_acc, s1_adv;
  logic                  s1_valid_q, s1_valid_d;
  sadq_res_t             s1_res_q, res;
  sadq_flags_t           flags;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [FieldW-1:0]     out_data_q;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [WideW-1:0]      wdata_wide, rdata_wide;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  push_op, pop_op, both_empty, s1_ovf, s1_unf;

  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  sadq_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .mode_i (mode_e'(mode_i)),
    .we_o   (we),
    .waddr_o(waddr),
    .re_o   (re),
    .raddr_o(raddr),
    .res_o  (res),
    .flags_o(flags)
  );

  assign wdata_wide = WideW'($unsigned(push_data_i));

  sadq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata_wide[DATA_WIDTH-1:0]),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rdata_wide  = WideW'(rdata);
  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= res;
    end
    if (s1_adv) begin
      out_status_q <= s1_res_q.status;
      out_data_q   <= s1_res_q.pop_ok ? rdata_wide[FieldW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pop_data_o  = $signed(out_data_q);
  assign status_o    = out_status_q;

  assign push_op    = (mode_e'(mode_i) == MODE_PUSH_L) || (mode_e'(mode_i) == MODE_PUSH_R);
  assign pop_op     = (mode_e'(mode_i) == MODE_POP);
  assign both_empty = flags.l_empty && flags.r_empty;
  assign s1_ovf     = s1_valid_q && (s1_res_q.status == ST_OVERFLOW);
  assign s1_unf     = s1_valid_q && (s1_res_q.status == ST_UNDERFLOW) && !s1_res_q.pop_ok;

  `SADQ_ASSERT(a_full_not_empty, !(flags.full && both_empty), "full with both queues empty")
  `SADQ_ASSERT(a_ovf, (in_acc && flags.full && push_op) |=> s1_ovf, "overflow not flagged")
  `SADQ_ASSERT(a_unf, (in_acc && both_empty && pop_op) |=> s1_unf, "underflow not flagged")

endmodule

// ===== tb/shared_array_dual_queue_top_tb.sv =====
// Testbench for shared_array_dual_queue_top: directed and random push/pop traffic
// with random idling on both channels, checked against an in-bench queue predictor.
// Depends on sadq_pkg and the shared_array_dual_queue_top RTL.
`timescale 1ns / 100ps

module shared_array_dual_queue_top_tb;
  import sadq_pkg::*;

  localparam int unsigned Depth = 8;

  typedef struct {
    logic [FieldW-1:0] data;
    status_e           status;
  } pop_result_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  mode_e             mode_i      = MODE_NONE;
  logic [FieldW-1:0] push_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [FieldW-1:0] pop_data_o;
  logic [StatusW-1:0] status_o;

  logic quiet = 1'b0;
  int   errors = 0;

  pop_result_t       pending_results[$];
  logic [FieldW-1:0] slot_mem[Depth];
  int                left_head;
  int                left_tail;
  int                right_head;
  int                right_tail;

  shared_array_dual_queue_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .push_data_i (push_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pop_data_o  (pop_data_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 21);
  end

  function automatic pop_result_t predict_queue(mode_e m, logic [FieldW-1:0] d);
    pop_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (m)
      MODE_PUSH_L, MODE_PUSH_R: begin
        if (left_tail + 1 == right_tail) begin
          r.status = ST_OVERFLOW;
        end else if (m == MODE_PUSH_L) begin
          if (left_head == -1) left_head = 0;
          left_tail++;
          slot_mem[left_tail] = d;
        end else begin
          if (right_head == Depth) right_head = Depth - 1;
          right_tail--;
          slot_mem[right_tail] = d;
        end
      end
      MODE_POP: begin
        if (left_tail != -1) begin
          r.data = slot_mem[left_head];
          if (left_head == left_tail) begin
            left_head = -1;
            left_tail = -1;
          end else begin
            left_head++;
          end
        end else if (right_tail != Depth) begin
          r.data = slot_mem[right_head];
          if (right_head == right_tail) begin
            right_head = Depth;
            right_tail = Depth;
          end else begin
            right_head--;
          end
        end else begin
          r.status = ST_UNDERFLOW;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_op(input mode_e m, input logic [FieldW-1:0] d);
    logic taken;
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    push_data_i <= d;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) pending_results.push_back(predict_queue(m, d));
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_results_done(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic logic [FieldW-1:0] pick_data();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic mode_e pick_mode(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return MODE_NONE;
    if (r < 3 + push_pct) return $urandom_range(1) ? MODE_PUSH_L : MODE_PUSH_R;
    return MODE_POP;
  endfunction

  initial begin : result_check
    pop_result_t exp_res;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transfer: pop_data %0h status %0d", pop_data_o, status_o);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (pop_data_o !== exp_res.data) begin
            $error("pop_data: expected %0h, got %0h", exp_res.data, pop_data_o);
            errors++;
          end
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_empty_and_unused();
    send_op(MODE_POP, 32'h1234_5678);
    send_op(MODE_NONE, 32'hdead_beef);
  endtask

  task automatic test_left_priority();
    send_op(MODE_PUSH_R, 32'h0000_00a1);
    send_op(MODE_PUSH_R, 32'h0000_00b2);
    send_op(MODE_PUSH_L, 32'h0000_00c3);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '1);
  endtask

  task automatic test_full_and_reclaim();
    send_op(MODE_PUSH_L, 32'h7fff_ffff);
    send_op(MODE_PUSH_L, 32'h8000_0000);
    send_op(MODE_PUSH_L, 32'h0000_0000);
    send_op(MODE_PUSH_L, 32'hffff_ffff);
    send_op(MODE_PUSH_L, 32'haaaa_aaaa);
    send_op(MODE_PUSH_L, 32'h5555_5555);
    send_op(MODE_PUSH_L, 32'h1111_1111);
    send_op(MODE_PUSH_R, 32'h2222_2222);
    send_op(MODE_POP, '0);
    send_op(MODE_PUSH_R, 32'h3333_3333);
    repeat (5) send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_NONE, 32'hffff_ffff);
  endtask

  task automatic test_random_traffic(input int bursts);
    int push_pct;
    repeat (bursts) begin
      push_pct = $urandom_range(1) ? 70 : 25;
      repeat ($urandom_range(20, 50)) send_op(pick_mode(push_pct), pick_data());
    end
  endtask

  task automatic test_back_to_back();
    quiet <= 1'b1;
    repeat (120) send_op(pick_mode($urandom_range(30, 65)), pick_data());
    quiet <= 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (30) send_op(pick_mode(60), pick_data());
    wait_results_done(4);
    repeat (40) send_op(pick_mode(45), pick_data());
  endtask

  initial begin : timeout
    #(2_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    left_head  = -1;
    left_tail  = -1;
    right_head = Depth;
    right_tail = Depth;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_unused();
    test_left_priority();
    test_full_and_reclaim();
    test_random_traffic(6);
    test_back_to_back();
    test_drain_pause();
    test_random_traffic(4);
    wait_results_done(8);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
